// ===== rtl/pidf_pkg.sv =====
package pidf_pkg;

    localparam int TIME_W   = 30;
    localparam int ID_W     = 11;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 32;
    localparam int ACNT_W   = 3;

    // Configuration data is as wide as the widest register (the period).
    localparam int CFG_DATA_W = TIME_W;

    // One step of the remainder unit per dividend bit.
    localparam int STEP_W = $clog2(TIME_W);

    localparam int TABLE_ENTRIES_DEF = 2048;
    localparam int ALLOWED_IDS_DEF   = 4;

    // Register indexes.
    localparam int REG_PERIOD        = 0;
    localparam int REG_ALLOWED_COUNT = 1;
    localparam int REG_ALLOWED_BASE  = 2;

    // Item codes.
    localparam logic                MODE_CLEAR   = 1'b1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SATELLITE = 2'd2;

    typedef struct packed {
        logic                mode;
        logic [ID_W-1:0]     message_id;
        logic [TIME_W-1:0]   time_ms;
        logic [STATUS_W-1:0] time_status;
    } t_in_item;

    typedef struct packed {
        logic               pass;
        logic [COUNT_W-1:0] pass_count;
    } t_out_item;

    typedef struct packed {
        logic              seen;
        logic [TIME_W-1:0] last_time;
    } t_entry;

endpackage

// ===== rtl/pidf_rem.sv =====
module pidf_rem #(
    parameter int TABLE_ENTRIES = pidf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pidf_pkg::TIME_W-1:0]        i_dividend,
    input  logic [pidf_pkg::TIME_W-1:0]        i_divisor,
    input  logic [pidf_pkg::ID_W-1:0]          i_id,
    output logic                               o_done,
    output logic                               o_zero,
    output logic [$clog2(TABLE_ENTRIES)-1:0]   o_slot
);

    localparam int TW    = pidf_pkg::TIME_W;
    localparam int IW    = pidf_pkg::ID_W;
    localparam int SW    = pidf_pkg::STEP_W;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    // Reciprocal of the table size, scaled so the quotient is exact for every IW-bit ID.
    localparam int SH    = IW + IDX_W;
    localparam int MW    = 2 * IW + 2;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));

    logic [SW-1:0]    r_cnt,  n_cnt;
    logic             r_run,  n_run;
    logic             r_done, n_done;
    logic [TW-1:0]    r_dsh,  n_dsh;
    logic [TW-1:0]    r_div,  n_div;
    logic [TW-1:0]    r_rem,  n_rem;
    logic [IW-1:0]    r_id,   n_id;
    logic [IW-1:0]    r_quo,  n_quo;
    logic [IDX_W-1:0] r_srem, n_srem;
    logic [TW:0]      trial;
    logic [MW-1:0]    prod;

    // Restoring remainder, one dividend bit per cycle. The table slot takes the ID
    // quotient from a reciprocal multiply at start and subtracts it back on the first step.
    always_comb begin
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        n_dsh  = r_dsh;
        n_div  = r_div;
        n_rem  = r_rem;
        n_id   = r_id;
        n_quo  = r_quo;
        n_srem = r_srem;
        trial  = {r_rem, r_dsh[TW-1]};
        prod   = MW'(i_id) * RECIP;
        if (i_start) begin
            n_cnt  = '0;
            n_run  = 1'b1;
            n_dsh  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
            n_id   = i_id;
            n_quo  = IW'(prod >> SH);
            n_srem = '0;
        end else if (r_run) begin
            n_dsh = r_dsh << 1;
            if (trial >= {1'b0, r_div}) begin
                n_rem = TW'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[TW-1:0];
            end
            if (r_cnt == '0) begin
                n_srem = IDX_W'(r_id - IW'(r_quo * IW'(TABLE_ENTRIES)));
            end
            n_cnt = r_cnt + SW'(1);
            if (r_cnt == SW'(TW - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_dsh  <= n_dsh;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_id   <= n_id;
        r_quo  <= n_quo;
        r_srem <= n_srem;
    end

    assign o_done = r_done;
    assign o_zero = (r_rem == '0);
    assign o_slot = r_srem;

endmodule

// ===== rtl/pidf_table.sv =====
module pidf_table #(
    parameter int TABLE_ENTRIES = pidf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_waddr,
    input  pidf_pkg::t_entry                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_raddr,
    output pidf_pkg::t_entry                 o_rdata
);

    pidf_pkg::t_entry r_mem [TABLE_ENTRIES];
    pidf_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/per_id_time_decimation_filter_unit.sv =====
// An item that passes at once (unknown or satellite time, zero period) gives its
// result in the cycle after it is taken; a filtered item after 30 remainder steps, one table
// read and one write-back; a clear item once the table is swept, one entry a cycle.
// One item a cycle is taken when items pass at once; busy stays high while a filtered item
// is worked and while a clear sweeps the table. Reset zeroes the counter and registers,
// then sweeps the whole table with busy high; the receiver cannot stall.
module per_id_time_decimation_filter_unit #(
    parameter int TABLE_ENTRIES = pidf_pkg::TABLE_ENTRIES_DEF,
    parameter int ALLOWED_IDS   = pidf_pkg::ALLOWED_IDS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  pidf_pkg::t_in_item                    i_item,
    output logic                                  o_valid,
    output pidf_pkg::t_out_item                   o_result,
    input  logic                                  i_cfg_we,
    input  logic [$clog2(ALLOWED_IDS + 2)-1:0]    i_cfg_idx,
    input  logic [pidf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CIDX_W = $clog2(ALLOWED_IDS + 2);
    localparam int TW     = pidf_pkg::TIME_W;
    localparam int IW     = pidf_pkg::ID_W;
    localparam int CW     = pidf_pkg::COUNT_W;
    localparam int AW     = pidf_pkg::ACNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;

    logic [2:0]          r_state, n_state;
    logic [IDX_W-1:0]    r_clr_addr, n_clr_addr;
    logic                r_clr_emit, n_clr_emit;
    logic [CW-1:0]       r_count, n_count;
    logic                r_valid, n_valid;
    pidf_pkg::t_out_item r_res, n_res;
    pidf_pkg::t_in_item  r_item, n_item;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic                r_mult, n_mult;

    logic [TW-1:0]       r_period;
    logic [AW-1:0]       r_allowed_count;
    logic [IW-1:0]       r_allowed [ALLOWED_IDS];

    logic                accept;
    logic                immediate;
    logic                allowed;
    logic                div_start;
    logic                div_done;
    logic                div_zero;
    logic [IDX_W-1:0]    div_slot;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    pidf_pkg::t_entry    mem_wdata;
    logic                mem_re;
    pidf_pkg::t_entry    mem_rdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period        <= '0;
            r_allowed_count <= '0;
            for (int k = 0; k < ALLOWED_IDS; k++) begin
                r_allowed[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CIDX_W'(pidf_pkg::REG_PERIOD)) begin
                r_period <= i_cfg_data[TW-1:0];
            end
            if (i_cfg_idx == CIDX_W'(pidf_pkg::REG_ALLOWED_COUNT)) begin
                r_allowed_count <= i_cfg_data[AW-1:0];
            end
            for (int k = 0; k < ALLOWED_IDS; k++) begin
                if (i_cfg_idx == CIDX_W'(pidf_pkg::REG_ALLOWED_BASE + k)) begin
                    r_allowed[k] <= i_cfg_data[IW-1:0];
                end
            end
        end
    end

    // A count above the list length uses the whole list.
    always_comb begin
        allowed = (r_allowed_count == '0);
        for (int k = 0; k < ALLOWED_IDS; k++) begin
            if (int'(r_allowed_count) > k && r_allowed[k] == r_item.message_id) begin
                allowed = 1'b1;
            end
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign accept    = i_start && !o_busy;
    assign immediate = (i_item.time_status inside {pidf_pkg::ST_UNKNOWN,
                                                   pidf_pkg::ST_SATELLITE})
                       || (r_period == '0);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_clr_emit = r_clr_emit;
        n_count    = r_count;
        n_valid    = 1'b0;
        n_res      = r_res;
        n_item     = r_item;
        n_slot     = r_slot;
        n_mult     = r_mult;
        div_start  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_slot;
        mem_wdata  = '{seen: 1'b1, last_time: r_item.time_ms};
        mem_re     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item = i_item;
                    if (i_item.mode == pidf_pkg::MODE_CLEAR) begin
                        n_count    = '0;
                        n_clr_addr = '0;
                        n_clr_emit = 1'b1;
                        n_state    = S_CLR;
                    end else if (immediate) begin
                        n_valid = 1'b1;
                        n_res   = '{pass: 1'b1, pass_count: r_count};
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_CLR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state    = S_IDLE;
                    n_clr_emit = 1'b0;
                    if (r_clr_emit) begin
                        n_valid = 1'b1;
                        n_res   = '{pass: 1'b0, pass_count: '0};
                    end
                end
            end
            S_DIV: begin
                // The slot is ready long before the remainder; read on completion.
                if (div_done) begin
                    mem_re  = 1'b1;
                    n_slot  = div_slot;
                    n_mult  = div_zero;
                    n_state = S_WB;
                end
            end
            S_WB: begin
                n_res.pass = 1'b0;
                if (!mem_rdata.seen) begin
                    if (r_mult && allowed) begin
                        mem_we     = 1'b1;
                        n_res.pass = 1'b1;
                    end
                end else if (mem_rdata.last_time == r_item.time_ms) begin
                    n_res.pass = 1'b1;
                end else if (r_mult) begin
                    mem_we     = 1'b1;
                    n_res.pass = 1'b1;
                end
                if (mem_we && r_count != '1) begin
                    n_count = r_count + CW'(1);
                end
                n_res.pass_count = n_count;
                n_valid          = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_clr_emit <= 1'b0;
            r_count    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_clr_emit <= n_clr_emit;
            r_count    <= n_count;
            r_valid    <= n_valid;
        end
        r_res  <= n_res;
        r_item <= n_item;
        r_slot <= n_slot;
        r_mult <= n_mult;
    end

    pidf_rem #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_item.time_ms),
        .i_divisor  (r_period),
        .i_id       (i_item.message_id),
        .o_done     (div_done),
        .o_zero     (div_zero),
        .o_slot     (div_slot)
    );

    pidf_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (div_slot),
        .o_rdata (mem_rdata)
    );

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import pidf_pkg::*;

    localparam logic                MODE_FILTER = 1'b0;
    localparam logic [STATUS_W-1:0] ST_ORDINARY = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RESERVED = 2'd3;
    localparam int CFG_IDX_W   = $clog2(ALLOWED_IDS_DEF + 2);
    localparam int PHASE_ITEMS = 179;
    localparam int TAIL_CYCLES = 40;
    // Slowest run: every item waits out the longest gap and the filter latency, and each
    // clear sweeps the whole table; that stays under a fifth of this limit.
    localparam int CYCLE_LIMIT = 1_000_000;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    t_in_item   i_item;
    logic       o_valid;
    t_out_item  o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    per_id_time_decimation_filter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    class decim_tracker;
        bit [TIME_W-1:0]   period_ms;
        bit [ACNT_W-1:0]   allowed_n;
        bit [ID_W-1:0]     allowed[ALLOWED_IDS_DEF];
        bit                seen[TABLE_ENTRIES_DEF];
        bit [TIME_W-1:0]   last_ms[TABLE_ENTRIES_DEF];
        bit [COUNT_W-1:0]  passes;
        t_out_item         verdicts[$];
        int unsigned       errors;
        int unsigned       results_seen;

        task report(input string what);
            if (errors < 100) begin
                $display("ERROR at %0t: %s", $time, what);
            end
            errors++;
        endtask

        function void write_reg(input int unsigned idx, input bit [CFG_DATA_W-1:0] data);
            if (idx == REG_PERIOD) begin
                period_ms = data[TIME_W-1:0];
            end else if (idx == REG_ALLOWED_COUNT) begin
                allowed_n = data[ACNT_W-1:0];
            end else if (idx >= REG_ALLOWED_BASE && idx < REG_ALLOWED_BASE + ALLOWED_IDS_DEF) begin
                allowed[idx - REG_ALLOWED_BASE] = data[ID_W-1:0];
            end
        endfunction

        function bit id_allowed(input bit [ID_W-1:0] id);
            int unsigned n;
            n = (allowed_n > ALLOWED_IDS_DEF) ? ALLOWED_IDS_DEF : allowed_n;
            if (n == 0) begin
                return 1'b1;
            end
            for (int k = 0; k < n; k++) begin
                if (allowed[k] == id) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // The table has as many entries as there are IDs, so the ID is the slot.
        function void note_message(input t_in_item it);
            t_out_item v;
            bit        on_grid;
            v.pass = 1'b0;
            if (it.mode == MODE_CLEAR) begin
                seen = '{default: 1'b0};
                passes = '0;
            end else if (it.time_status == ST_UNKNOWN || it.time_status == ST_SATELLITE ||
                         period_ms == 0) begin
                v.pass = 1'b1;
            end else begin
                on_grid = (it.time_ms % period_ms) == 0;
                if (!seen[it.message_id]) begin
                    if (on_grid && id_allowed(it.message_id)) begin
                        seen[it.message_id] = 1'b1;
                        last_ms[it.message_id] = it.time_ms;
                        if (passes != '1) passes++;
                        v.pass = 1'b1;
                    end
                end else if (last_ms[it.message_id] == it.time_ms) begin
                    v.pass = 1'b1;
                end else if (on_grid) begin
                    last_ms[it.message_id] = it.time_ms;
                    if (passes != '1) passes++;
                    v.pass = 1'b1;
                end
            end
            v.pass_count = passes;
            verdicts.push_back(v);
        endfunction

        task check_verdict(input t_out_item got);
            t_out_item want;
            results_seen++;
            if (verdicts.size() == 0) begin
                report($sformatf("result %0d arrived with no item pending (pass=%0d count=%0d)",
                                 results_seen, got.pass, got.pass_count));
                return;
            end
            want = verdicts.pop_front();
            if (got.pass !== want.pass) begin
                report($sformatf("result %0d: pass %0b, expected %0b",
                                 results_seen, got.pass, want.pass));
            end
            if (got.pass_count !== want.pass_count) begin
                report($sformatf("result %0d: pass_count %0d, expected %0d",
                                 results_seen, got.pass_count, want.pass_count));
            end
        endtask
    endclass

    decim_tracker sb;
    int unsigned  cycle_count = 0;
    int unsigned  burst_left = 0;
    int unsigned  clears_left = 40;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_verdict(o_result);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic issue(input t_in_item it);
        int unsigned gap;
        i_item  <= it;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        sb.note_message(it);
        if (burst_left != 0) begin
            gap = 0;
            burst_left--;
        end else if ($urandom_range(0, 19) == 0) begin
            gap = 0;
            burst_left = $urandom_range(8, 30);
        end else begin
            gap = $urandom_range(0, 18);
        end
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait for every pending result and for any table sweep to finish.
    task automatic settle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (sb.verdicts.size() != 0 || o_busy);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Writes every register index, the unused ones too; unused data bits carry noise.
    task automatic load_config(input bit [TIME_W-1:0] period, input bit [ACNT_W-1:0] acnt,
                               input bit [ALLOWED_IDS_DEF-1:0][ID_W-1:0] ids);
        bit [CFG_DATA_W-1:0] data;
        for (int r = 0; r < 2**CFG_IDX_W; r++) begin
            data = CFG_DATA_W'($urandom);
            if (r == REG_PERIOD) begin
                data = period;
            end else if (r == REG_ALLOWED_COUNT) begin
                data[ACNT_W-1:0] = acnt;
            end else if (r >= REG_ALLOWED_BASE && r < REG_ALLOWED_BASE + ALLOWED_IDS_DEF) begin
                data[ID_W-1:0] = ids[r - REG_ALLOWED_BASE];
            end
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(r);
            i_cfg_data <= data;
            @(posedge i_clk);
            sb.write_reg(r, data);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item msg(input int unsigned id, input int unsigned ms,
                                     input logic [STATUS_W-1:0] st);
        return '{MODE_FILTER, ID_W'(id), TIME_W'(ms), st};
    endfunction

    // Mostly IDs from a small pool and times on the period grid, so that
    // repeats, updates and allowed-list lookups happen often.
    function automatic t_in_item random_item(input bit [TIME_W-1:0] period,
                                             input bit [7:0][ID_W-1:0] pool);
        t_in_item    it;
        int unsigned kmax;
        int unsigned pick;
        it.mode = MODE_FILTER;
        if (clears_left != 0 && $urandom_range(0, 49) == 0) begin
            it.mode = MODE_CLEAR;
            clears_left--;
        end
        if ($urandom_range(0, 9) < 7) begin
            it.message_id = pool[$urandom_range(0, 7)];
        end else begin
            it.message_id = ID_W'($urandom);
        end
        if (period != 0 && $urandom_range(0, 9) < 7) begin
            kmax = 32'h3FFF_FFFF / period;
            if (kmax > 8) kmax = 8;
            it.time_ms = TIME_W'(period * $urandom_range(0, kmax));
        end else if ($urandom_range(0, 1) == 0) begin
            it.time_ms = TIME_W'($urandom_range(0, 604799999));
        end else begin
            it.time_ms = TIME_W'($urandom);
        end
        pick = $urandom_range(0, 11);
        if (pick < 8) begin
            it.time_status = ST_ORDINARY;
        end else if (pick == 8) begin
            it.time_status = ST_UNKNOWN;
        end else if (pick == 9) begin
            it.time_status = ST_SATELLITE;
        end else begin
            it.time_status = ST_RESERVED;
        end
        return it;
    endfunction

    initial begin
        bit [TIME_W-1:0]                   period;
        bit [ACNT_W-1:0]                   acnt;
        bit [ALLOWED_IDS_DEF-1:0][ID_W-1:0] ids;
        bit [7:0][ID_W-1:0]                pool;

        sb = new;
        i_rst_n    <= 1'b0;
        i_start    <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        load_config(30'd1000, 3'd2, {11'd100, 11'd0, 11'h7FF, 11'd5});
        issue(msg(5, 3000, ST_ORDINARY));
        issue(msg(5, 3000, ST_ORDINARY));
        issue(msg(5, 3500, ST_ORDINARY));
        issue(msg(5, 4000, ST_ORDINARY));
        issue(msg(7, 5000, ST_ORDINARY));
        issue(msg(7, 5000, ST_UNKNOWN));
        issue(msg(7, 5001, ST_SATELLITE));
        issue(msg(2047, 0, ST_RESERVED));
        issue(msg(2047, 30'h3FFF_FFFF, ST_ORDINARY));
        // ID 0 sits in a register past the allowed count.
        issue(msg(0, 604799000, ST_ORDINARY));
        issue(msg(5, 604799000, ST_ORDINARY));
        issue('{MODE_CLEAR, 11'h7FF, 30'h3FFF_FFFF, ST_RESERVED});
        issue(msg(5, 3000, ST_ORDINARY));
        settle();

        // A count above the list size uses every entry; ID 5 stays known though not listed.
        load_config(30'h3FFF_FFFF, 3'd7, {11'h7FF, 11'd3, 11'd2, 11'd1});
        issue(msg(5, 0, ST_ORDINARY));
        issue(msg(2047, 30'h3FFF_FFFF, ST_ORDINARY));
        issue(msg(4, 0, ST_ORDINARY));
        issue(msg(2047, 30'h3FFF_FFFF, ST_RESERVED));
        settle();

        load_config(30'd0, 3'd0, '0);
        issue(msg(9, 12345, ST_ORDINARY));
        issue(msg(2047, 1, ST_ORDINARY));

        for (int p = 0; p < 8; p++) begin
            acnt = ACNT_W'($urandom);
            case (p)
                0: begin period = 30'd1000;       acnt = 3'd0; end
                1: begin period = 30'd1;          acnt = 3'd3; end
                2: begin period = 30'd604800000;  acnt = 3'd4; end
                3: begin period = 30'h3FFF_FFFF;  acnt = 3'd7; end
                4: begin period = 30'd0; end
                5: begin period = TIME_W'($urandom_range(2, 5000)); end
                6: begin period = 30'd60000;      acnt = 3'd1; end
                default: begin
                    period = TIME_W'($urandom_range(1, 604800000));
                    acnt   = 3'd0;
                end
            endcase
            for (int k = 0; k < ALLOWED_IDS_DEF; k++) begin
                ids[k] = ID_W'($urandom);
            end
            if (p == 3) begin
                ids[0] = '0;
                ids[ALLOWED_IDS_DEF-1] = '1;
            end
            pool[3:0] = ids;
            for (int k = 4; k < 8; k++) begin
                pool[k] = ID_W'($urandom);
            end
            if (p % 2 == 0) begin
                pool[4] = '0;
                pool[5] = '1;
            end
            settle();
            load_config(period, acnt, ids);
            repeat (PHASE_ITEMS) issue(random_item(period, pool));
        end

        settle();
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pidf_pkg.sv
rtl/pidf_rem.sv
rtl/pidf_table.sv
rtl/per_id_time_decimation_filter_unit.sv
tb/sv/tb.sv
